// File: design/rfde_pkg.sv
// Shared types and constants for the register frame delta encoder.
`default_nettype none

package rfde_pkg;

  // First register of the upper change-mask group
  localparam int unsigned LOW_GROUP = 8;
  // Envelope-shape register; 0xFF there means "no rewrite"
  localparam int unsigned SKIP_REG  = 13;
  localparam logic [7:0]  SKIP_VAL  = 8'hFF;
  // Largest frame gap that fits in the stream
  localparam logic [7:0]  GAP_LIMIT = 8'd254;
  localparam logic [7:0]  GAP_SAT   = 8'hFF;
  localparam logic [7:0]  END_MARK  = 8'hFF;

  // Source of the byte loaded into the output register
  typedef enum logic [2:0] {
    SEL_GAP,
    SEL_MLOW,
    SEL_MHIGH,
    SEL_REG,
    SEL_ZERO,
    SEL_END,
    SEL_ERR
  } emit_sel_e;

  typedef struct packed {
    logic      wr_cur;     // store input byte at index
    logic      cmp;        // latch change mask, copy frame to previous
    logic      gap_inc;    // saturating gap increment
    logic      gap_set1;   // gap back to one
    logic      prev_clr;   // previous frame back to zero
    logic      emit;       // load output register
    logic      emit_last;  // tlast of the loaded word
    emit_sel_e sel;
  } dp_cmd_t;

  typedef struct packed {
    logic any_change;   // some register differs (live compare)
    logic gap_over;     // gap above the limit
    logic idx_changed;  // latched mask bit at index
    logic more_above;   // latched mask has bits above index
    logic high_any;     // latched upper group nonzero
    logic slot_free;    // output register can take a word
  } dp_stat_t;

endpackage

`default_nettype wire

// File: design/rfde_dp.sv
// Datapath: frame stores, change mask, gap counter and output register.
`default_nettype none

module rfde_dp #(
  parameter int unsigned NUM_REGS = 14
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire rfde_pkg::dp_cmd_t               cmd_i,
  input  wire logic [$clog2(NUM_REGS)-1:0]     idx_i,
  input  wire logic [7:0]                      wr_data_i,
  output rfde_pkg::dp_stat_t                   stat_o,
  input  wire logic                            out_ready_i,
  output logic                                 out_valid_o,
  output logic [7:0]                           out_byte_o,
  output logic                                 out_last_o,
  output logic                                 out_err_o
);

  localparam int unsigned IDX_W = $clog2(NUM_REGS);

  logic [7:0]          cur_q  [NUM_REGS];
  logic [7:0]          prev_q [NUM_REGS];
  logic [NUM_REGS-1:0] mask_q;
  logic [NUM_REGS-1:0] changed_now;
  logic [7:0]          gap_q;
  logic [7:0]          m_low;
  logic [7:0]          m_high;
  logic                more_above;
  logic                slot_free;
  logic                valid_q;
  logic [7:0]          byte_q;
  logic                last_q;
  logic                err_q;
  logic [7:0]          emit_byte;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_cur) begin
      cur_q[idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) prev_q[i] <= '0;
    end else if (cmd_i.prev_clr) begin
      for (int i = 0; i < NUM_REGS; i++) prev_q[i] <= '0;
    end else if (cmd_i.cmp) begin
      for (int i = 0; i < NUM_REGS; i++) prev_q[i] <= cur_q[i];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      changed_now[i] = (cur_q[i] != prev_q[i]);
      if (i == int'(rfde_pkg::SKIP_REG) && cur_q[i] == rfde_pkg::SKIP_VAL) begin
        changed_now[i] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      mask_q <= changed_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= 8'd1;
    end else if (cmd_i.gap_set1) begin
      gap_q <= 8'd1;
    end else if (cmd_i.gap_inc && gap_q != rfde_pkg::GAP_SAT) begin
      gap_q <= gap_q + 8'd1;
    end
  end

  assign m_low  = mask_q[rfde_pkg::LOW_GROUP-1:0];
  assign m_high = 8'(mask_q[NUM_REGS-1:rfde_pkg::LOW_GROUP]);

  always_comb begin
    more_above = 1'b0;
    for (int j = 0; j < NUM_REGS; j++) begin
      if (IDX_W'(j) > idx_i && mask_q[j]) more_above = 1'b1;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      rfde_pkg::SEL_GAP:   emit_byte = gap_q;
      rfde_pkg::SEL_MLOW:  emit_byte = m_low;
      rfde_pkg::SEL_MHIGH: emit_byte = m_high;
      rfde_pkg::SEL_REG:   emit_byte = cur_q[idx_i];
      rfde_pkg::SEL_END:   emit_byte = rfde_pkg::END_MARK;
      default:             emit_byte = 8'd0;
    endcase
  end

  assign slot_free = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      byte_q <= emit_byte;
      last_q <= cmd_i.emit_last;
      err_q  <= (cmd_i.sel == rfde_pkg::SEL_ERR);
    end
  end

  assign stat_o.any_change  = |changed_now;
  assign stat_o.gap_over    = (gap_q > rfde_pkg::GAP_LIMIT);
  assign stat_o.idx_changed = mask_q[idx_i];
  assign stat_o.more_above  = more_above;
  assign stat_o.high_any    = |m_high;
  assign stat_o.slot_free   = slot_free;

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

endmodule

`default_nettype wire

// File: design/rfde_ctrl.sv
// Controller: byte gathering, compare and the emission sequence.
`default_nettype none

module rfde_ctrl #(
  parameter int unsigned NUM_REGS = 14
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic                        in_final_i,
  input  wire rfde_pkg::dp_stat_t          stat_i,
  output rfde_pkg::dp_cmd_t                cmd_o,
  output logic [$clog2(NUM_REGS)-1:0]      idx_o
);

  localparam int unsigned IDX_W = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0] IDX_LAST    = IDX_W'(NUM_REGS - 1);
  localparam logic [IDX_W-1:0] IDX_LOW_END = IDX_W'(rfde_pkg::LOW_GROUP - 1);
  localparam logic [IDX_W-1:0] IDX_HIGH    = IDX_W'(rfde_pkg::LOW_GROUP);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CMP   = 4'd1;
  localparam logic [3:0] S_GAP   = 4'd2;
  localparam logic [3:0] S_MLOW  = 4'd3;
  localparam logic [3:0] S_LOW   = 4'd4;
  localparam logic [3:0] S_MHIGH = 4'd5;
  localparam logic [3:0] S_HIGH  = 4'd6;
  localparam logic [3:0] S_FCHK  = 4'd7;
  localparam logic [3:0] S_FGAP  = 4'd8;
  localparam logic [3:0] S_FZ1   = 4'd9;
  localparam logic [3:0] S_FZ2   = 4'd10;
  localparam logic [3:0] S_FEND  = 4'd11;
  localparam logic [3:0] S_ERR   = 4'd12;
  localparam logic [3:0] S_HALT  = 4'd13;

  logic [3:0]       state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             fin_q, fin_d;
  logic             accept;

  assign in_ready_o = (state_q == S_IDLE) || (state_q == S_HALT);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_o      = cnt_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    cmd_o   = '0;
    cmd_o.sel = rfde_pkg::SEL_ZERO;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.wr_cur = 1'b1;
          if (cnt_q == IDX_LAST) begin
            fin_d   = in_final_i;
            cnt_d   = '0;
            state_d = S_CMP;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        if (stat_i.any_change) begin
          state_d = stat_i.gap_over ? S_ERR : S_GAP;
        end else begin
          cmd_o.gap_inc = 1'b1;
          state_d = fin_q ? S_FCHK : S_IDLE;
        end
      end
      S_GAP: begin
        if (stat_i.slot_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.sel      = rfde_pkg::SEL_GAP;
          cmd_o.gap_set1 = 1'b1;
          state_d = S_MLOW;
        end
      end
      S_MLOW: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = rfde_pkg::SEL_MLOW;
          cnt_d   = '0;
          state_d = S_LOW;
        end
      end
      S_LOW: begin
        if (!stat_i.idx_changed || stat_i.slot_free) begin
          cmd_o.emit = stat_i.idx_changed;
          cmd_o.sel  = rfde_pkg::SEL_REG;
          if (cnt_q == IDX_LOW_END) begin
            state_d = S_MHIGH;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_MHIGH: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = rfde_pkg::SEL_MHIGH;
          cmd_o.emit_last = !fin_q && !stat_i.high_any;
          cnt_d   = IDX_HIGH;
          state_d = S_HIGH;
        end
      end
      S_HIGH: begin
        if (!stat_i.idx_changed || stat_i.slot_free) begin
          cmd_o.emit      = stat_i.idx_changed;
          cmd_o.sel       = rfde_pkg::SEL_REG;
          cmd_o.emit_last = !fin_q && !stat_i.more_above;
          if (cnt_q == IDX_LAST) begin
            cnt_d   = '0;
            state_d = fin_q ? S_FGAP : S_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_FCHK: begin
        state_d = stat_i.gap_over ? S_ERR : S_FGAP;
      end
      S_FGAP: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.sel  = rfde_pkg::SEL_GAP;
          state_d = S_FZ1;
        end
      end
      S_FZ1: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_FZ2;
        end
      end
      S_FZ2: begin
        if (stat_i.slot_free) begin
          cmd_o.emit = 1'b1;
          state_d = S_FEND;
        end
      end
      S_FEND: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = rfde_pkg::SEL_END;
          cmd_o.emit_last = 1'b1;
          cmd_o.prev_clr  = 1'b1;
          cmd_o.gap_set1  = 1'b1;
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat_i.slot_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.sel       = rfde_pkg::SEL_ERR;
          cmd_o.emit_last = 1'b1;
          state_d = S_HALT;
        end
      end
      S_HALT: begin
        // words are taken and dropped until reset
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
    end
  end

endmodule

`default_nettype wire

// File: design/register_frame_delta_encoder_unit.sv
// Top level of the register frame delta encoder.
//
//  channel  dir  tdata (low bit up)   tlast         tuser
//  s_axis   in   register_value[7:0]  -             final_frame
//  m_axis   out  out_byte[7:0]        last_in_run   gap_error
//
// A register byte that is not the last of its frame is simply stored.
// The last byte of a frame adds a compare step. An unchanged frame stops
// there, or with the end marker goes compare, gap check, gap, 0, 0, 0xFF.
// A changed frame walks gap, low mask, 8 register slots, high mask and
// NUM_REGS-8 register slots, one slot a cycle unless a word waits for the
// output register, and holds off the input meanwhile; the end marker then
// adds gap, 0, 0, 0xFF. A gap error yields one error word. Unchanged registers
// still cost a slot. Reset clears the previous frame, gap (to one) and control;
// the output register holds its word through any m_axis stall; emitting steps wait.
// After a gap error the input keeps being accepted and dropped until reset.
`default_nettype none

module register_frame_delta_encoder_unit #(
  parameter int unsigned NUM_REGS = 14   // registers per frame, 9 to 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] register_value
  input  wire logic       s_axis_tuser,   // [0] final_frame
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
  output logic            m_axis_tlast,   // last_in_run
  output logic            m_axis_tuser    // [0] gap_error
);

  rfde_pkg::dp_cmd_t             cmd;
  rfde_pkg::dp_stat_t            stat;
  logic [$clog2(NUM_REGS)-1:0]   idx;

  // Sequencer: byte position, compare decision, emission order
  rfde_ctrl #(
    .NUM_REGS (NUM_REGS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_final_i (s_axis_tuser),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  // Frame stores, change mask, gap count and the output word register
  rfde_dp #(
    .NUM_REGS (NUM_REGS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .wr_data_i   (s_axis_tdata),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (m_axis_tuser)
  );

endmodule

`default_nettype wire

// File: bench/tb_register_frame_delta_encoder_unit.sv
// Self-checking bench for the register frame delta encoder: random frames and stalls.
`timescale 1ns / 100ps

module tb_register_frame_delta_encoder_unit;

  localparam int unsigned NREGS       = 14;      // registers per frame
  localparam int          CYCLE_LIMIT = 400000;  // watchdog, several times the slowest run
  localparam int          SETTLE      = 40;      // > longest frame walk plus slack

  // One word of the encoded change stream
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } stream_word_t;

  // Tracks the encoder's frame state and the change-stream words it owes.
  class delta_stream_sb;
    logic [7:0]   prev_regs [NREGS];
    logic [7:0]   cur_regs  [NREGS];
    int           byte_idx;
    logic [7:0]   frame_gap;
    bit           halted;
    stream_word_t due_words [$];
    stream_word_t staged    [$];
    int mismatches, words_checked, bytes_taken;
    int frames_emitted, end_marks, gap_errors;

    function new();
      foreach (prev_regs[i]) begin
        prev_regs[i] = 8'h00;
        cur_regs[i]  = 8'h00;
      end
      byte_idx  = 0;
      frame_gap = 8'd1;
      halted    = 1'b0;
    endfunction

    function bit reg_changed(int i);
      if (i == rfde_pkg::SKIP_REG && cur_regs[i] == rfde_pkg::SKIP_VAL) return 1'b0;
      return cur_regs[i] != prev_regs[i];
    endfunction

    function void stage(logic [7:0] b, logic err);
      stream_word_t w;
      w.data = b;
      w.last = 1'b0;
      w.err  = err;
      staged.push_back(w);
    endfunction

    // Predict the words caused by one accepted register byte.
    function void take_register_byte(logic [7:0] value, logic fin);
      logic [7:0] mask_lo, mask_hi;
      bit         any;
      bytes_taken++;
      if (halted) return;
      cur_regs[byte_idx] = value;
      if (byte_idx < NREGS - 1) begin
        byte_idx++;
        return;
      end
      byte_idx = 0;
      mask_lo  = 8'h00;
      mask_hi  = 8'h00;
      any      = 1'b0;
      staged.delete();
      for (int i = 0; i < NREGS; i++) begin
        if (reg_changed(i)) begin
          any = 1'b1;
          if (i < rfde_pkg::LOW_GROUP) mask_lo[i] = 1'b1;
          else mask_hi[i - rfde_pkg::LOW_GROUP] = 1'b1;
        end
      end
      if (any) begin
        if (frame_gap > rfde_pkg::GAP_LIMIT) begin
          // overflowing gap: a lone error word, then dead until reset
          halted = 1'b1;
          gap_errors++;
          stage(8'h00, 1'b1);
          staged[0].last = 1'b1;
          due_words.push_back(staged[0]);
          return;
        end
        stage(frame_gap, 1'b0);
        stage(mask_lo, 1'b0);
        for (int i = 0; i < NREGS; i++) begin
          if (i == rfde_pkg::LOW_GROUP) stage(mask_hi, 1'b0);
          if (reg_changed(i)) stage(cur_regs[i], 1'b0);
        end
        frame_gap = 8'd1;
        frames_emitted++;
      end else if (frame_gap != rfde_pkg::GAP_SAT) begin
        frame_gap++;
      end
      prev_regs = cur_regs;
      if (fin) begin
        if (frame_gap > rfde_pkg::GAP_LIMIT) begin
          halted = 1'b1;
          gap_errors++;
          stage(8'h00, 1'b1);
        end else begin
          stage(frame_gap, 1'b0);
          stage(8'h00, 1'b0);
          stage(8'h00, 1'b0);
          stage(rfde_pkg::END_MARK, 1'b0);
          foreach (prev_regs[i]) prev_regs[i] = 8'h00;
          frame_gap = 8'd1;
          end_marks++;
        end
      end
      if (staged.size() > 0) begin
        staged[staged.size() - 1].last = 1'b1;
        foreach (staged[i]) due_words.push_back(staged[i]);
      end
    endfunction

    function void report(string what, stream_word_t e, stream_word_t a);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s: expected data=%02h last=%0b err=%0b, got data=%02h last=%0b err=%0b",
                 $time, what, e.data, e.last, e.err, a.data, a.last, a.err);
    endfunction

    // Compare one accepted output word with the oldest one due.
    function void check_stream_word(logic [7:0] b, logic last, logic err);
      stream_word_t got, want;
      got.data = b;
      got.last = last;
      got.err  = err;
      words_checked++;
      if (due_words.size() == 0) begin
        want = '0;
        report("word with nothing due", want, got);
        return;
      end
      want = due_words.pop_front();
      if (got.data !== want.data || got.last !== want.last || got.err !== want.err)
        report("word mismatch", want, got);
    endfunction
  endclass

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       s_axis_tuser  = 1'b0;
  logic       m_axis_tready = 1'b0;
  wire        s_axis_tready;
  wire        m_axis_tvalid;
  wire  [7:0] m_axis_tdata;
  wire        m_axis_tlast;
  wire        m_axis_tuser;

  int send_idle_pct  = 0;  // chance of a sender gap before a word
  int recv_stall_pct = 0;  // chance of tready low in a cycle
  int cycle_count    = 0;

  delta_stream_sb sb;

  register_frame_delta_encoder_unit #(.NUM_REGS(NREGS)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk_i = ~clk_i;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Output side: values read right after the edge are the ones the DUT saw,
  // so a word counts when tvalid and tready were both high at that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready)
        sb.check_stream_word(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one register byte and hold it until the DUT takes it. tvalid stays
  // high between back-to-back words; a sender gap lowers it before the word.
  task automatic send_word(input logic [7:0] value, input logic fin);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.take_register_byte(value, fin);
  endtask

  // One frame: each register is kept from the last frame or rewritten with
  // chance change_pct. final_frame only matters on the last byte, so the
  // earlier bytes carry random tuser to show it is ignored there.
  task automatic send_frame(input int change_pct, input bit fin, input bit force_change);
    logic [7:0] vals [NREGS];
    for (int i = 0; i < NREGS; i++) begin
      if ($urandom_range(0, 99) < change_pct) begin
        case ($urandom_range(0, 7))
          0: vals[i] = 8'h00;
          1: vals[i] = 8'hFF;
          default: vals[i] = 8'($urandom);
        endcase
        // the envelope register's "no rewrite" value shows up often
        if (i == rfde_pkg::SKIP_REG && $urandom_range(0, 3) == 0)
          vals[i] = rfde_pkg::SKIP_VAL;
      end else begin
        vals[i] = sb.prev_regs[i];
      end
    end
    if (force_change) vals[0] = sb.prev_regs[0] ^ 8'h5A;
    for (int i = 0; i < NREGS; i++)
      send_word(vals[i], (i == NREGS - 1) ? fin : 1'($urandom_range(0, 1)));
  endtask

  // Hold the sender off until every due word has come out, then let the
  // encoder finish any walk that produces nothing more.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    int kind;
    int pct;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: all-ones frame with the envelope register at its skip value
    // (stored but not flagged), then an all-zero final frame that changes
    // every register and closes the song -- the longest possible run.
    for (int i = 0; i < NREGS; i++) send_word(8'hFF, 1'b0);
    for (int i = 0; i < NREGS; i++) send_word(8'h00, (i == NREGS - 1));
    drain();

    // Random frames under four idling profiles.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int f = 0; f < 8; f++) begin
        kind = $urandom_range(0, 99);
        pct  = (kind < 15) ? 0 : (kind < 25) ? 100 : 30;
        send_frame(pct, ($urandom_range(0, 9) == 0), 1'b0);
      end
      drain();
    end

    if (sb.due_words.size() != 0)
      $display("%0d words still due at the end", sb.due_words.size());
    $display("Run: %0d register bytes in, %0d stream words checked, %0d mismatches",
             sb.bytes_taken, sb.words_checked, sb.mismatches);
    $display("Covered: %0d changed frames, %0d end markers, %0d gap errors, %0d cycles",
             sb.frames_emitted, sb.end_marks, sb.gap_errors, cycle_count);
    if (sb.mismatches == 0 && sb.due_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
